// File: design/akf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// akf_pkg: shared types and constants for the angle Kalman fusion block
// Holds register indexes and the command and status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package akf_pkg;

	// Register indexes on the configuration port
	localparam int unsigned REG_ANGLE_Q = 0;
	localparam int unsigned REG_BIAS_Q  = 1;
	localparam int unsigned REG_MEAS_R  = 2;

	// Reset values of the registers
	localparam logic [30:0] ANGLE_Q_RST = 31'd1049;
	localparam logic [30:0] BIAS_Q_RST  = 31'd3146;
	localparam logic [30:0] MEAS_R_RST  = 31'd524288;

	// Datapath operations, one per microstep
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,     // latch inputs, compute dt, g - bias
		OP_PRED,     // angle += (g-b)*dt
		OP_PD,       // pd0, pd1
		OP_P0,       // P0 += pd0*dt
		OP_P1,       // P1 += pd1*dt
		OP_P2,       // P2 += pd1*dt
		OP_P3,       // P3 += qg*dt
		OP_E,        // e = rm + P0, err
		OP_DIV0,     // start k0 = P0/e
		OP_DIV1,     // start k1 = P1/e
		OP_ANG,      // angle += k0*err
		OP_BIAS,     // bias += k1*err
		OP_C0,       // P0 -= k0*pc0
		OP_C1,       // P1 -= k0*pc1
		OP_C2,       // P2 -= k1*pc0
		OP_C3,       // P3 -= k1*pc1
		OP_OUT       // form outputs
	} op_t;

	typedef struct packed {
		op_t  op;
		logic mul_phase;  // 0: issue product, 1: accumulate product
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} status_t;

endpackage
`default_nettype wire

// File: design/akf_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// akf_divider: restoring fixed-point divider
// Computes round(n * 2^FRAC / d), ties away from zero, saturated, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module akf_divider #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 20
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire signed [DATA_WIDTH-1:0]  num,
	input  wire signed [DATA_WIDTH-1:0]  den,
	output logic                         busy,
	output logic signed [DATA_WIDTH-1:0] quot
);
	localparam int NW = DATA_WIDTH + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]         n_q;
	logic [DATA_WIDTH:0]   r_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [NW-1:0]         qt_q;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q;
	logic                  zero_q;
	logic                  nzero_q;
	logic                  fin_q;

	logic [DATA_WIDTH:0]   r_sh;
	logic [DATA_WIDTH:0]   r_nx;
	logic                  take;
	logic [NW:0]           qr;
	logic [DATA_WIDTH:0]   lim;
	logic signed [DATA_WIDTH-1:0] sat;
	logic [DATA_WIDTH-1:0] nm;
	logic [DATA_WIDTH-1:0] dm;

	assign nm = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : num;
	assign dm = den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : den;

	// one restoring step
	assign r_sh = {r_q[DATA_WIDTH-1:0], n_q[NW-1]};
	assign take = (r_sh >= {1'b0, d_q});
	assign r_nx = take ? (r_sh - {1'b0, d_q}) : r_sh;

	// rounding from the final remainder, then saturation
	always_comb begin
		qr  = {1'b0, qt_q} + (NW+1)'((r_q >= ({1'b0, d_q} - r_q)) ? 1 : 0);
		lim = neg_q ? {2'b01, {(DATA_WIDTH-1){1'b0}}} : {2'b00, {(DATA_WIDTH-1){1'b1}}};
		if (qr > (NW+1)'(lim)) qr = (NW+1)'(lim);
		sat = neg_q ? DATA_WIDTH'(-qr[DATA_WIDTH-1:0]) : qr[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (start) begin
			busy    <= 1'b1;
			cnt_q   <= CW'(NW);
			fin_q   <= 1'b0;
			n_q     <= {nm, {FRAC_BITS{1'b0}}};
			d_q     <= dm;
			r_q     <= '0;
			qt_q    <= '0;
			neg_q   <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
			zero_q  <= (den == '0);
			nzero_q <= (num == '0);
		end else if (busy) begin
			if (cnt_q != '0) begin
				r_q   <= r_nx;
				n_q   <= {n_q[NW-2:0], 1'b0};
				qt_q  <= {qt_q[NW-2:0], take};
				cnt_q <= cnt_q - 1'b1;
			end else if (!fin_q) begin
				fin_q <= 1'b1;
				// zero divisor: full scale with the sign of the numerator, zero over zero
				if (zero_q)
					quot <= nzero_q ? '0
						: ((neg_q) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
						: {1'b0, {(DATA_WIDTH-1){1'b1}}});
				else
					quot <= sat;
				busy <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: design/akf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// akf_datapath: filter state, shared multiplier and saturating adder
// One product at a time through a registered rounded multiplier;
// gains come from the shared divider.
// ----------------------------------------------------------------------------
module akf_datapath #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 20
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  akf_pkg::cmd_t        cmd,
	output akf_pkg::status_t     status,
	input  wire [30:0]           qa_cfg,
	input  wire [30:0]           qg_cfg,
	input  wire [30:0]           rm_cfg,
	input  wire signed [31:0]    gyro_rate,
	input  wire signed [31:0]    accel_angle,
	input  wire [9:0]            step_ms,
	output logic signed [31:0]   fused_angle,
	output logic signed [31:0]   corrected_rate
);
	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * W;
	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE  = W'(64'sd1 <<< FRAC_BITS);
	localparam int DTW = 10 + FRAC_BITS + 1;
	// reciprocal of 1000 scaled by 2^DK, exact floor for any DTW-bit numerator
	localparam int DK = DTW + 10;
	localparam logic [DK:0] DPOW = (DK+1)'(1) << DK;
	localparam logic [DK:0] DREC = (DPOW + (DK+1)'(999)) / (DK+1)'(1000);

	typedef logic signed [W-1:0] val_t;

	// saturate a value of W+2 bits width extended
	function automatic val_t clampw(input logic signed [W+1:0] a);
		if (a > (W+2)'(VMAX)) return VMAX;
		if (a < (W+2)'(VMIN)) return VMIN;
		return a[W-1:0];
	endfunction

	function automatic val_t sadd(input val_t a, input val_t b);
		return clampw((W+2)'(a) + (W+2)'(b));
	endfunction

	function automatic val_t ssub(input val_t a, input val_t b);
		return clampw((W+2)'(a) - (W+2)'(b));
	endfunction

	// clamp a 32-bit signed field or 31-bit register into W bits
	function automatic val_t fit32(input logic signed [32:0] a);
		if (a > 33'(VMAX) && W < 33) return VMAX;
		if (a < 33'(VMIN) && W < 33) return VMIN;
		return W'(a);
	endfunction

	// saturate to the 32-bit output range
	function automatic logic signed [31:0] sat32(input val_t v);
		if (W > 32) begin
			if ((W+1)'(v) > (W+1)'(33'sh07FFFFFFF)) return 32'sh7FFFFFFF;
			if ((W+1)'(v) < (W+1)'(-33'sh080000000)) return 32'sh80000000;
		end
		return 32'(v);
	endfunction

	val_t ang_q, bias_q, p0_q, p1_q, p2_q, p3_q;
	val_t g_q, acc_q, dt_q, gb_q, pd0_q, pd1_q, pc0_q, pc1_q, e_q, err_q, k0_q, k1_q;
	val_t ma, mb;
	val_t prod_s1;

	logic [PW-1:0] pmag;
	logic [PW:0]   prnd;
	logic [PW-FRAC_BITS:0] psh;
	logic [W:0]    plim;
	logic          pneg;
	logic [W-1:0]  am, bm;
	val_t          pval;
	logic [DTW-1:0] dtn;
	logic [2*DTW:0] dtp;
	logic [2*DTW:0] dtv;
	val_t          dt_w;
	logic          div_start;
	val_t          div_num;
	val_t          quot;
	logic          div_busy;

	// operand select for the shared multiplier
	always_comb begin
		ma = gb_q; mb = dt_q;
		case (cmd.op)
			akf_pkg::OP_PRED: begin ma = gb_q;  mb = dt_q;  end
			akf_pkg::OP_P0:   begin ma = pd0_q; mb = dt_q;  end
			akf_pkg::OP_P1, akf_pkg::OP_P2: begin ma = pd1_q; mb = dt_q; end
			akf_pkg::OP_P3:   begin ma = fit32({2'b00, qg_cfg}); mb = dt_q; end
			akf_pkg::OP_ANG:  begin ma = k0_q;  mb = err_q; end
			akf_pkg::OP_BIAS: begin ma = k1_q;  mb = err_q; end
			akf_pkg::OP_C0:   begin ma = k0_q;  mb = pc0_q; end
			akf_pkg::OP_C1:   begin ma = k0_q;  mb = pc1_q; end
			akf_pkg::OP_C2:   begin ma = k1_q;  mb = pc0_q; end
			akf_pkg::OP_C3:   begin ma = k1_q;  mb = pc1_q; end
			default: ;
		endcase
	end

	// rounded, saturated product of magnitudes
	always_comb begin
		am   = ma[W-1] ? W'(-ma) : ma;
		bm   = mb[W-1] ? W'(-mb) : mb;
		pneg = ma[W-1] ^ mb[W-1];
		pmag = PW'(am) * PW'(bm);
		prnd = (PW+1)'(pmag) + ((PW+1)'(1) << (FRAC_BITS - 1));
		psh  = prnd[PW:FRAC_BITS];
		plim = pneg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
		if (psh > (PW-FRAC_BITS+1)'(plim)) psh = (PW-FRAC_BITS+1)'(plim);
		pval = pneg ? W'(-psh[W-1:0]) : psh[W-1:0];
	end

	// dt = round(step * 2^FRAC / 1000) through the reciprocal of 1000
	assign dtn = (DTW'(step_ms) << FRAC_BITS) + DTW'(500);
	assign dtp = (2*DTW+1)'(dtn) * (2*DTW+1)'(DREC[DTW:0]);

	always_comb begin
		dtv  = dtp >> DK;
		dt_w = (dtv > (2*DTW+1)'(VMAX)) ? VMAX : W'(dtv);
	end

	assign div_start = (cmd.op == akf_pkg::OP_DIV0) || (cmd.op == akf_pkg::OP_DIV1);
	assign div_num   = (cmd.op == akf_pkg::OP_DIV0) ? pc0_q : pc1_q;

	akf_divider #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (e_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign status.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			p0_q   <= ONE;
			p1_q   <= '0;
			p2_q   <= '0;
			p3_q   <= ONE;
		end else begin
			if (!cmd.mul_phase) prod_s1 <= pval;
			case (cmd.op)
				akf_pkg::OP_LOAD: begin
					g_q   <= fit32(33'(gyro_rate));
					acc_q <= fit32(33'(accel_angle));
					dt_q  <= dt_w;
					gb_q  <= ssub(fit32(33'(gyro_rate)), bias_q);
				end
				akf_pkg::OP_PRED: if (cmd.mul_phase) ang_q <= sadd(ang_q, prod_s1);
				akf_pkg::OP_PD: begin
					pd0_q <= ssub(ssub(fit32({2'b00, qa_cfg}), p1_q), p2_q);
					pd1_q <= ssub('0, p3_q);
				end
				akf_pkg::OP_P0: if (cmd.mul_phase) p0_q <= sadd(p0_q, prod_s1);
				akf_pkg::OP_P1: if (cmd.mul_phase) p1_q <= sadd(p1_q, prod_s1);
				akf_pkg::OP_P2: if (cmd.mul_phase) p2_q <= sadd(p2_q, prod_s1);
				akf_pkg::OP_P3: if (cmd.mul_phase) p3_q <= sadd(p3_q, prod_s1);
				akf_pkg::OP_E: begin
					pc0_q <= p0_q;
					pc1_q <= p1_q;
					e_q   <= sadd(fit32({2'b00, rm_cfg}), p0_q);
					err_q <= ssub(acc_q, ang_q);
				end
				akf_pkg::OP_DIV1: k0_q <= quot;
				akf_pkg::OP_ANG: begin
					if (!cmd.mul_phase) k1_q <= quot;
					else ang_q <= sadd(ang_q, prod_s1);
				end
				akf_pkg::OP_BIAS: if (cmd.mul_phase) bias_q <= sadd(bias_q, prod_s1);
				akf_pkg::OP_C0: if (cmd.mul_phase) p0_q <= ssub(p0_q, prod_s1);
				akf_pkg::OP_C1: if (cmd.mul_phase) p1_q <= ssub(p1_q, prod_s1);
				akf_pkg::OP_C2: if (cmd.mul_phase) p2_q <= ssub(p2_q, prod_s1);
				akf_pkg::OP_C3: if (cmd.mul_phase) p3_q <= ssub(p3_q, prod_s1);
				akf_pkg::OP_OUT: begin
					fused_angle    <= 32'(sat32(ang_q));
					corrected_rate <= 32'(sat32(ssub(g_q, bias_q)));
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/akf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// akf_ctrl: sequencer for one filter step
// Walks the datapath through its operations, issue then accumulate per
// product, waits on the divider, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module akf_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_fire,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  akf_pkg::status_t  status,
	output akf_pkg::cmd_t     cmd
);
	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} state_t;

	state_t        state_q;
	akf_pkg::op_t  op_q;
	logic          ph_q;

	// the request is latched at the accepting edge itself
	assign cmd.op        = (state_q == ST_RUN) ? op_q
		: (in_fire ? akf_pkg::OP_LOAD : akf_pkg::OP_NONE);
	assign cmd.mul_phase = ph_q;
	// next item may enter while idle or in the cycle the result is taken
	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_DONE && out_ready);

	function automatic logic is_mul(input akf_pkg::op_t o);
		case (o)
			akf_pkg::OP_PRED, akf_pkg::OP_P0, akf_pkg::OP_P1, akf_pkg::OP_P2,
			akf_pkg::OP_P3, akf_pkg::OP_ANG, akf_pkg::OP_BIAS, akf_pkg::OP_C0,
			akf_pkg::OP_C1, akf_pkg::OP_C2, akf_pkg::OP_C3: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= akf_pkg::OP_NONE;
			ph_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE, ST_DONE: begin
					if (out_valid && out_ready) out_valid <= 1'b0;
					if (in_fire) begin
						state_q <= ST_RUN;
						op_q    <= akf_pkg::OP_PRED;
						ph_q    <= 1'b0;
					end else if (state_q == ST_DONE && out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (is_mul(op_q) && !ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (op_q == akf_pkg::OP_DIV0 || op_q == akf_pkg::OP_DIV1) begin
							state_q <= ST_WAIT;
						end else if (op_q == akf_pkg::OP_OUT) begin
							state_q   <= ST_DONE;
							out_valid <= 1'b1;
						end else begin
							op_q <= akf_pkg::op_t'(op_q + 1'b1);
						end
					end
				end
				ST_WAIT: begin
					// once busy falls, ph_q is set before the next operation is entered
					if (!status.div_busy && !ph_q) ph_q <= 1'b1;
					else if (!status.div_busy && ph_q) begin
						ph_q    <= 1'b0;
						state_q <= ST_RUN;
						op_q    <= akf_pkg::op_t'(op_q + 1'b1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ap_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !out_valid) else $error("result shown while running");
	ap_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_RUN && op_q == akf_pkg::OP_PRED))
		else $error("accept did not start a step");
	ap_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> out_valid || in_ready) else $error("done without result");
endmodule
`default_nettype wire

// File: design/angle_kalman_fusion_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// angle_kalman_fusion_top: angle and gyro-bias Kalman filter
// Fuses gyro rate and accelerometer angle into a fused angle and a
// bias-corrected rate, signed fixed point, saturated.
// ----------------------------------------------------------------------------
// One item at a time: a step runs from the accept to a valid result through
// the bit-serial divider that forms the two gains, one after the other, plus
// eleven products on one shared multiplier, an issue and an accumulate phase
// each. The result waits in an output register and the next item is taken
// in the cycle the result leaves.
module angle_kalman_fusion_top #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 20
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [79:0] s_tdata,   // gyro_rate[31:0], accel_angle[63:32], step_ms[73:64]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata    // fused_angle[31:0], corrected_rate[63:32]
);
	logic [30:0] qa_q, qg_q, rm_q;
	akf_pkg::cmd_t    cmd;
	akf_pkg::status_t status;
	logic signed [31:0] fa, cr;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= akf_pkg::ANGLE_Q_RST;
			qg_q <= akf_pkg::BIAS_Q_RST;
			rm_q <= akf_pkg::MEAS_R_RST;
		end else if (wr) begin
			case (paddr[3:2])
				2'(akf_pkg::REG_ANGLE_Q): qa_q <= pwdata[30:0];
				2'(akf_pkg::REG_BIAS_Q):  qg_q <= pwdata[30:0];
				2'(akf_pkg::REG_MEAS_R):  rm_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			2'(akf_pkg::REG_ANGLE_Q): prdata = {1'b0, qa_q};
			2'(akf_pkg::REG_BIAS_Q):  prdata = {1'b0, qg_q};
			2'(akf_pkg::REG_MEAS_R):  prdata = {1'b0, rm_q};
			default: prdata = '0;
		endcase
	end

	akf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (s_tvalid && s_tready),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	akf_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.qa_cfg         (qa_q),
		.qg_cfg         (qg_q),
		.rm_cfg         (rm_q),
		.gyro_rate      (s_tdata[31:0]),
		.accel_angle    (s_tdata[63:32]),
		.step_ms        (s_tdata[73:64]),
		.fused_angle    (fa),
		.corrected_rate (cr)
	);

	assign m_tdata = {cr, fa};
endmodule
`default_nettype wire
